/* hw/rtl/rvalu_pkg.sv */
// Shared types and constants for the RV32IM integer ALU pipeline.
// Depends on nothing; used by rv32im_integer_alu and the testbench.
`default_nettype none
package rvalu_pkg;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MEXT = 7'b0000001;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam int unsigned DivSteps = 32;

  typedef enum logic [1:0] {
    K_BASE = 2'd0,
    K_MUL  = 2'd1,
    K_DIV  = 2'd2,
    K_REM  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        ill;
    logic        hi;
    logic        sa;
    logic        sb;
    logic        negq;
    logic        negr;
    logic        dz;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } stage_t;

endpackage
`default_nettype wire

/* hw/rtl/rv32im_integer_alu.sv */
// RV32IM integer ALU, pipelined. Uses rvalu_pkg and rvalu_div_step.
//
// Input channel: valid_i/stall_o with command_i, funct3_i, funct7_i,
// operand_a_i, operand_b_i. A beat is taken at a rising edge with valid_i
// high and stall_o low. Output channel: valid_o/stall_i with result_o and
// illegal_o; a beat leaves at an edge with valid_o high and stall_i low.
// Every operation takes the same path: the beat passes one decode stage, 32
// division stages (one quotient bit each; the first also holds the 33x33
// multiplier result) and the output register, which takes the fix-up.
// Throughput is one beat per cycle while the receiver does not stall: every stage
// advances when the stage after it is empty or advancing, so bubbles close up
// under a stall and a new beat is taken while a result waits as long as some stage is empty.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the output beat holds and the pipeline fills
// behind it; stall_o rises only once every stage is occupied.
// Illegal funct3/funct7 combinations give illegal_o high and result_o zero.
`default_nettype none
module rv32im_integer_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        command_i,
  input  wire logic [2:0]  funct3_i,
  input  wire logic [6:0]  funct7_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      result_o,
  output logic             illegal_o
);
  import rvalu_pkg::*;

  localparam int unsigned NStage = DivSteps + 1;

  stage_t           st_q [NStage];
  stage_t           st_d [NStage];
  logic [NStage-1:0] v_q;
  logic [NStage-1:0] en;
  logic             out_v_q;
  logic             out_en;
  logic [31:0]      result_q;
  logic             illegal_q;
  logic [31:0]      result_d;
  logic [65:0]      prod;
  logic [31:0]      mul_res;

  // ---------------- advance chain ----------------
  assign out_en = !out_v_q || !stall_i;
  always_comb begin
    en[NStage-1] = !v_q[NStage-1] || out_en;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign stall_o = !en[0];

  // ---------------- decode ----------------
  always_comb begin
    logic        mext;
    logic        plain_ok;
    logic        sgn;
    logic [4:0]  sh;
    st_d[0]      = '0;
    st_d[0].kind = K_BASE;
    mext         = !command_i && (funct7_i == F7_MEXT);
    plain_ok     = command_i || (funct7_i == F7_BASE);
    sh           = operand_b_i[4:0];
    sgn          = (funct3_i == F3_DIV) || (funct3_i == F3_REM);
    st_d[0].quo  = operand_a_i;
    st_d[0].dvs  = operand_b_i;
    if (mext) begin
      unique case (funct3_i)
        F3_MUL, F3_MULH, F3_MULHSU, F3_MULHU: st_d[0].kind = K_MUL;
        F3_DIV, F3_DIVU:                      st_d[0].kind = K_DIV;
        default:                              st_d[0].kind = K_REM;
      endcase
      st_d[0].hi   = funct3_i != F3_MUL;
      st_d[0].sa   = (funct3_i == F3_MULH) || (funct3_i == F3_MULHSU);
      st_d[0].sb   = funct3_i == F3_MULH;
      st_d[0].dz   = operand_b_i == '0;
      st_d[0].negq = sgn && (operand_a_i[31] ^ operand_b_i[31]) && (operand_b_i != '0);
      st_d[0].negr = sgn && operand_a_i[31];
      if ((funct3_i == F3_DIV) || (funct3_i == F3_REM)) begin
        if (operand_a_i[31]) st_d[0].quo = 32'd0 - operand_a_i;
        if (operand_b_i[31]) st_d[0].dvs = 32'd0 - operand_b_i;
      end
    end else begin
      unique case (funct3_i)
        F3_ADD: begin
          if (plain_ok) st_d[0].res = operand_a_i + operand_b_i;
          else if (funct7_i == F7_ALT) st_d[0].res = operand_a_i - operand_b_i;
          else st_d[0].ill = 1'b1;
        end
        F3_SLL: begin
          if (plain_ok) st_d[0].res = operand_a_i << sh;
          else st_d[0].ill = 1'b1;
        end
        F3_SLT: begin
          if (plain_ok) st_d[0].res = {31'd0, $signed(operand_a_i) < $signed(operand_b_i)};
          else st_d[0].ill = 1'b1;
        end
        F3_SLTU: begin
          if (plain_ok) st_d[0].res = {31'd0, operand_a_i < operand_b_i};
          else st_d[0].ill = 1'b1;
        end
        F3_XOR: begin
          if (plain_ok) st_d[0].res = operand_a_i ^ operand_b_i;
          else st_d[0].ill = 1'b1;
        end
        F3_SR: begin
          if (funct7_i == F7_BASE) st_d[0].res = operand_a_i >> sh;
          else if (funct7_i == F7_ALT) st_d[0].res = 32'($signed(operand_a_i) >>> sh);
          else st_d[0].ill = 1'b1;
        end
        F3_OR: begin
          if (plain_ok) st_d[0].res = operand_a_i | operand_b_i;
          else st_d[0].ill = 1'b1;
        end
        default: begin
          if (plain_ok) st_d[0].res = operand_a_i & operand_b_i;
          else st_d[0].ill = 1'b1;
        end
      endcase
    end
  end

  // ---------------- multiplier (feeds stage 1) ----------------
  assign prod = 66'($signed({st_q[0].sa & st_q[0].quo[31], st_q[0].quo}) *
                    $signed({st_q[0].sb & st_q[0].dvs[31], st_q[0].dvs}));
  assign mul_res = st_q[0].hi ? prod[63:32] : prod[31:0];

  // ---------------- division stages ----------------
  for (genvar k = 1; k < NStage; k++) begin : g_div
    logic [31:0] rem_n;
    logic [31:0] quo_n;

    rvalu_div_step u_step (
      .rem_i (st_q[k-1].rem),
      .quo_i (st_q[k-1].quo),
      .dvs_i (st_q[k-1].dvs),
      .rem_o (rem_n),
      .quo_o (quo_n)
    );

    always_comb begin
      st_d[k]     = st_q[k-1];
      st_d[k].rem = rem_n;
      st_d[k].quo = quo_n;
      if ((k == 1) && (st_q[k-1].kind == K_MUL)) st_d[k].res = mul_res;
    end
  end

  for (genvar k = 0; k < NStage; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q[0] <= en[0] ? valid_i : v_q[0];
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- fix-up and output register ----------------
  always_comb begin
    unique case (st_q[NStage-1].kind)
      K_DIV: begin
        if (st_q[NStage-1].dz) result_d = '1;
        else if (st_q[NStage-1].negq) result_d = 32'd0 - st_q[NStage-1].quo;
        else result_d = st_q[NStage-1].quo;
      end
      K_REM: begin
        if (st_q[NStage-1].negr) result_d = 32'd0 - st_q[NStage-1].rem;
        else result_d = st_q[NStage-1].rem;
      end
      default: result_d = st_q[NStage-1].res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= v_q[NStage-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      result_q  <= result_d;
      illegal_q <= st_q[NStage-1].ill;
    end
  end

  assign valid_o   = out_v_q;
  assign result_o  = result_q;
  assign illegal_o = illegal_q;

  // ---------------- assertions ----------------
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (out_v_q && stall_i && (&v_q)))
    else $error("input stalled while pipeline has room");

  a_ill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && illegal_o) |-> (result_o == '0))
    else $error("illegal result is not zero");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NStage-1] && !(out_v_q && stall_i)) |=> out_v_q)
    else $error("finished beat lost before output register");

  a_head_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v_q[0])
    else $error("accepted beat not in decode stage");

endmodule
`default_nettype wire

/* hw/rtl/rvalu_div_step.sv */
// One restoring division step: shift in a dividend bit, trial subtract.
// Depends on nothing but its ports.
`default_nettype none
module rvalu_div_step (
  input  wire logic [31:0] rem_i,
  input  wire logic [31:0] quo_i,
  input  wire logic [31:0] dvs_i,
  output logic      [31:0] rem_o,
  output logic      [31:0] quo_o
);
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {rem_i, quo_i[31]};
    diff  = trial - {1'b0, dvs_i};
    if (!diff[32]) begin
      rem_o = diff[31:0];
      quo_o = {quo_i[30:0], 1'b1};
    end else begin
      rem_o = trial[31:0];
      quo_o = {quo_i[30:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for rv32im_integer_alu: directed and random ALU beats.
// Depends on rvalu_pkg and the rv32im_integer_alu RTL.
`default_nettype none
module tb;
  import rvalu_pkg::*;

  localparam int unsigned PipeDepth = 34;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] result;
    logic        illegal;
  } alu_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        command_i = 1'b0;
  logic [2:0]  funct3_i = '0;
  logic [6:0]  funct7_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] result_o;
  logic        illegal_o;

  alu_out_t    pending_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;

  rv32im_integer_alu i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic alu_out_t compute_alu(logic cmd, logic [2:0] f3, logic [6:0] f7,
                                           logic [31:0] a, logic [31:0] b);
    alu_out_t    o;
    logic [63:0] prod;
    logic [31:0] q;
    logic        plain_ok;
    o = '0;
    plain_ok = cmd || f7 == F7_BASE;
    if (!cmd && f7 == F7_MEXT) begin
      case (f3)
        F3_MUL:    o.result = a * b;
        F3_MULH: begin
          prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          o.result = prod[63:32];
        end
        F3_MULHSU: begin
          prod = {{32{a[31]}}, a} * {32'd0, b};
          o.result = prod[63:32];
        end
        F3_MULHU: begin
          prod = {32'd0, a} * {32'd0, b};
          o.result = prod[63:32];
        end
        F3_DIV: begin
          if (b == 0) o.result = '1;
          else if (a == 32'h8000_0000 && b == '1) o.result = 32'h8000_0000;
          else begin
            q = magnitude(a) / magnitude(b);
            o.result = (a[31] != b[31]) ? (32'd0 - q) : q;
          end
        end
        F3_DIVU:   o.result = (b == 0) ? '1 : a / b;
        F3_REM: begin
          if (b == 0) o.result = a;
          else if (a == 32'h8000_0000 && b == '1) o.result = 0;
          else begin
            q = magnitude(a) % magnitude(b);
            o.result = a[31] ? (32'd0 - q) : q;
          end
        end
        default:   o.result = (b == 0) ? a : a % b;
      endcase
    end else begin
      case (f3)
        F3_ADD: begin
          if (plain_ok) o.result = a + b;
          else if (f7 == F7_ALT) o.result = a - b;
          else o.illegal = 1'b1;
        end
        F3_SLL:  if (plain_ok) o.result = a << b[4:0]; else o.illegal = 1'b1;
        F3_SLT:  if (plain_ok) o.result = {31'd0, $signed(a) < $signed(b)};
                 else o.illegal = 1'b1;
        F3_SLTU: if (plain_ok) o.result = {31'd0, a < b}; else o.illegal = 1'b1;
        F3_XOR:  if (plain_ok) o.result = a ^ b; else o.illegal = 1'b1;
        F3_SR: begin
          if (f7 == F7_BASE) o.result = a >> b[4:0];
          else if (f7 == F7_ALT) o.result = $unsigned($signed(a) >>> b[4:0]);
          else o.illegal = 1'b1;
        end
        F3_OR:   if (plain_ok) o.result = a | b; else o.illegal = 1'b1;
        default: if (plain_ok) o.result = a & b; else o.illegal = 1'b1;
      endcase
    end
    if (o.illegal) o.result = '0;
    return o;
  endfunction

  // valid stays high after the accepting edge; the next call either drops it
  // at the following negedge or replaces the payload there
  task automatic send_op(logic cmd, logic [2:0] f3, logic [6:0] f7,
                         logic [31:0] a, logic [31:0] b, bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : rand_gap();
    repeat (gap) @(negedge clk_i) valid_i <= 1'b0;
    @(negedge clk_i);
    valid_i     <= 1'b1;
    command_i   <= cmd;
    funct3_i    <= f3;
    funct7_i    <= f7;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (stall_o);
    pending_q.push_back(compute_alu(cmd, f3, f7, a, b));
  endtask

  task automatic release_valid();
    @(negedge clk_i) valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return '1;
      2: return $urandom_range(0, 3);
      3: return $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] rand_f7();
    case ($urandom_range(0, 7))
      0, 1: return F7_BASE;
      2, 3: return F7_ALT;
      4, 5: return F7_MEXT;
      default: return 7'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edge_vals[4];
    edge_vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int f = 0; f < 8; f++) begin
      send_op(1'b0, 3'(f), F7_BASE, edge_vals[f % 4], edge_vals[(f + 1) % 4]);
      send_op(1'b0, 3'(f), F7_MEXT, edge_vals[f % 4], edge_vals[(f + 2) % 4]);
    end
    send_op(1'b0, F3_ADD, F7_ALT, 32'h0, 32'h1);
    send_op(1'b0, F3_SR, F7_ALT, 32'h8000_0000, 32'd31);
    send_op(1'b1, F3_SR, F7_ALT, 32'hF000_0000, 32'hFFFF_FC04);
    send_op(1'b1, F3_SLL, 7'h7F, 32'h1, 32'hFFFF_FFFF);
    send_op(1'b1, F3_SR, 7'h7F, 32'h1, 32'h1);
    send_op(1'b0, F3_OR, 7'h7F, 32'h1, 32'h1);
    send_op(1'b0, F3_DIV, F7_MEXT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(1'b0, F3_REM, F7_MEXT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(1'b0, F3_REMU, F7_MEXT, 32'h1234_5678, 32'h0);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++)
      send_op($urandom_range(0, 3) == 0, 3'($urandom), rand_f7(),
              rand_operand(), rand_operand(), n % 200 < 40);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    test_random(80);
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) stall_i <= 1'b1;
      else if ($urandom_range(0, 49) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(5, 40)) @(negedge clk_i);
        stall_i <= 1'b0;
      end else stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    alu_out_t exp_beat;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat result=%h illegal=%b", $time, result_o, illegal_o);
        error_count++;
      end else begin
        exp_beat = pending_q.pop_front();
        if (result_o !== exp_beat.result) begin
          $display("%0t: result expected %h actual %h", $time, exp_beat.result, result_o);
          error_count++;
        end
        if (illegal_o !== exp_beat.illegal) begin
          $display("%0t: illegal expected %b actual %b", $time, exp_beat.illegal, illegal_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1650);
    release_valid();
    wait (pending_q.size() == 0);
    repeat (PipeDepth * 2) @(posedge clk_i);
    if (error_count == 0 && pending_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_div_step.sv
hw/rtl/rv32im_integer_alu.sv
tb/tb.sv
